### hdl/abpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpw_pkg
// Shared types and constants of the alpha blend pixel writer.
// ----------------------------------------------------------------------------
package abpw_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SZ_W      = 13;
    localparam int POS_W     = 16;
    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int PIX_W     = 20;
    localparam int SUM_W     = 2 * CH_W;

    localparam logic [CH_W-1:0] FULL_OPACITY = 8'hFF;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic CMD_BLEND = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_OOB     = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### hdl/abpw_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpw_blend
// Source-over blend of three 8-bit channels with exact division by 255.
// ----------------------------------------------------------------------------
module abpw_blend (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [abpw_pkg::RGB_W-1:0] i_old,
    input  logic [abpw_pkg::RGB_W-1:0] i_src,
    input  logic [abpw_pkg::CH_W-1:0]  i_alpha,
    output logic [abpw_pkg::RGB_W-1:0] o_rgb
);

    logic [abpw_pkg::SUM_W-1:0] r_sum [3];
    logic [abpw_pkg::CH_W-1:0]  inv_alpha;
    logic [abpw_pkg::SUM_W:0]   q_tmp [3];

    assign inv_alpha = abpw_pkg::FULL_OPACITY - i_alpha;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= abpw_pkg::SUM_W'(i_old[c*abpw_pkg::CH_W +: abpw_pkg::CH_W])
                                * abpw_pkg::SUM_W'(inv_alpha)
                          + abpw_pkg::SUM_W'(i_src[c*abpw_pkg::CH_W +: abpw_pkg::CH_W])
                                * abpw_pkg::SUM_W'(i_alpha);
            end
        end
    end

    // Exact floor(v / 255) for v up to 255 * 255.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            q_tmp[c] = (abpw_pkg::SUM_W+1)'(r_sum[c])
                     + (abpw_pkg::SUM_W+1)'(r_sum[c] >> abpw_pkg::CH_W)
                     + (abpw_pkg::SUM_W+1)'(1);
            o_rgb[c*abpw_pkg::CH_W +: abpw_pkg::CH_W] =
                q_tmp[c][abpw_pkg::CH_W +: abpw_pkg::CH_W];
        end
    end

endmodule

### hdl/alpha_blend_pixel_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_pixel_writer_core
// Blends ARGB pixels into a 24-bit RGB frame store and reads pixels back.
// ----------------------------------------------------------------------------
// Input beats arrive on the s channel: tdata carries pos_x, pos_y, alpha,
// src_red, src_green and src_blue, and tuser carries the command (blend or
// read). Every input beat yields exactly one result beat on the m channel:
// tdata carries pixel_index, out_red, out_green and out_blue, and tuser
// carries status and counted.
// The cfg channel writes screen_width (index 0) and screen_height (index 1);
// it is always ready and should only be used while the block is idle.
// One beat is handled at a time. The result is registered after the index,
// read, multiply and divide states, and the next beat is accepted in the cycle
// after the result is taken, so a new beat waits until the last one is done.
// The frame store is one synchronous memory with a read port and a write
// port; each beat does an index multiply, a memory read, a blend multiply,
// a divide and, for a blend that is written, a write back.
// After reset the store is cleared one entry per cycle, all 1048576 entries;
// s_tready stays low during that pass.
// A stalled receiver holds the result in the output register, and no new
// input beat is taken until it is accepted.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_writer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // [15:0] pos_x, [31:16] pos_y, [39:32] alpha, [47:40] src_red,
    // [55:48] src_green, [63:56] src_blue
    input  logic [63:0]                    s_tdata,
    // [0] cmd
    input  logic [0:0]                     s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [19:0] pixel_index, [27:20] out_red, [35:28] out_green,
    // [43:36] out_blue, [47:44] zero
    output logic [47:0]                    m_tdata,
    // [1:0] status, [2] counted
    output logic [2:0]                     m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [abpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [abpw_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int MUL_W = abpw_pkg::POS_W + abpw_pkg::SZ_W;

    abpw_pkg::t_state r_state, n_state;

    logic [abpw_pkg::ADDR_W-1:0] r_clr_addr;
    logic [abpw_pkg::CFG_W-1:0]  r_width;
    logic [abpw_pkg::CFG_W-1:0]  r_height;

    logic                        r_cmd;
    logic [abpw_pkg::POS_W-1:0]  r_x;
    logic [abpw_pkg::POS_W-1:0]  r_y;
    logic [abpw_pkg::CH_W-1:0]   r_alpha;
    logic [abpw_pkg::RGB_W-1:0]  r_src;
    logic                        r_inside;
    logic [abpw_pkg::ADDR_W-1:0] r_idx;
    logic [abpw_pkg::RGB_W-1:0]  r_rd_data;

    logic [abpw_pkg::RGB_W-1:0]  r_mem [abpw_pkg::STORE_DEPTH];

    abpw_pkg::t_status           r_status;
    logic                        r_counted;
    logic [abpw_pkg::PIX_W-1:0]  r_pix;
    logic [abpw_pkg::RGB_W-1:0]  r_rgb;

    logic                        s_accept;
    logic                        mem_we;
    logic [abpw_pkg::ADDR_W-1:0] mem_wa;
    logic [abpw_pkg::RGB_W-1:0]  mem_wd;
    logic                        blend_en;
    logic                        do_write;
    logic [abpw_pkg::RGB_W-1:0]  blend_rgb;

    logic [abpw_pkg::SZ_W-1:0]   w_ext, h_ext, w_eff, h_eff;
    logic                        in_bounds;
    logic [MUL_W-1:0]            idx_full;

    abpw_pkg::t_status           n_status;
    logic                        n_counted;
    logic [abpw_pkg::PIX_W-1:0]  n_pix;
    logic [abpw_pkg::RGB_W-1:0]  n_rgb;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = (r_state == abpw_pkg::S_IDLE);
    assign m_tvalid    = (r_state == abpw_pkg::S_OUT);
    assign s_accept    = s_tvalid && s_tready;
    assign blend_en    = (r_state == abpw_pkg::S_MUL);

    assign m_tdata = {4'd0, r_rgb[7:0], r_rgb[15:8], r_rgb[23:16], r_pix};
    assign m_tuser = {r_counted, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abpw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            abpw_pkg::S_CLEAR: begin
                if (r_clr_addr == abpw_pkg::ADDR_W'(abpw_pkg::STORE_DEPTH - 1)) begin
                    n_state = abpw_pkg::S_IDLE;
                end
            end
            abpw_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_state = abpw_pkg::S_INDEX;
                end
            end
            abpw_pkg::S_INDEX: n_state = abpw_pkg::S_READ;
            abpw_pkg::S_READ:  n_state = abpw_pkg::S_MUL;
            abpw_pkg::S_MUL:   n_state = abpw_pkg::S_DIV;
            abpw_pkg::S_DIV:   n_state = abpw_pkg::S_OUT;
            abpw_pkg::S_OUT: begin
                if (m_tready) begin
                    n_state = abpw_pkg::S_IDLE;
                end
            end
            default: n_state = abpw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_width    <= abpw_pkg::WIDTH_RESET;
            r_height   <= abpw_pkg::HEIGHT_RESET;
        end else begin
            if (r_state == abpw_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + abpw_pkg::ADDR_W'(1);
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == abpw_pkg::REG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == abpw_pkg::REG_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
        end
    end

    // Index calculation with the configured size clamped to the store.
    always_comb begin
        w_ext     = abpw_pkg::SZ_W'(r_width);
        h_ext     = abpw_pkg::SZ_W'(r_height);
        w_eff     = (w_ext > abpw_pkg::SZ_W'(abpw_pkg::MAX_WIDTH))
                  ? abpw_pkg::SZ_W'(abpw_pkg::MAX_WIDTH) : w_ext;
        h_eff     = (h_ext > abpw_pkg::SZ_W'(abpw_pkg::MAX_HEIGHT))
                  ? abpw_pkg::SZ_W'(abpw_pkg::MAX_HEIGHT) : h_ext;
        in_bounds = (r_x < abpw_pkg::POS_W'(w_eff)) && (r_y < abpw_pkg::POS_W'(h_eff));
        idx_full  = MUL_W'(r_y) * MUL_W'(w_eff) + MUL_W'(r_x);
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd   <= s_tuser[0];
            r_x     <= s_tdata[15:0];
            r_y     <= s_tdata[31:16];
            r_alpha <= s_tdata[39:32];
            r_src   <= {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
        end
        if (r_state == abpw_pkg::S_INDEX) begin
            r_inside <= in_bounds;
            r_idx    <= in_bounds ? abpw_pkg::ADDR_W'(idx_full) : '0;
        end
    end

    abpw_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (blend_en),
        .i_old   (r_rd_data),
        .i_src   (r_src),
        .i_alpha (r_alpha),
        .o_rgb   (blend_rgb)
    );

    always_comb begin
        do_write  = 1'b0;
        n_status  = abpw_pkg::ST_OOB;
        n_counted = 1'b0;
        n_pix     = '0;
        n_rgb     = '0;
        priority if (r_cmd == abpw_pkg::CMD_READ) begin
            if (r_inside) begin
                n_status = abpw_pkg::ST_READ;
                n_pix    = abpw_pkg::PIX_W'(r_idx);
                n_rgb    = r_rd_data;
            end
        end else if (r_alpha == '0) begin
            n_status  = abpw_pkg::ST_SKIPPED;
            n_counted = 1'b1;
            if (r_inside) begin
                n_pix = abpw_pkg::PIX_W'(r_idx);
                n_rgb = r_rd_data;
            end
        end else begin
            if (r_inside) begin
                do_write  = 1'b1;
                n_status  = abpw_pkg::ST_WRITTEN;
                n_counted = 1'b1;
                n_pix     = abpw_pkg::PIX_W'(r_idx);
                n_rgb     = blend_rgb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == abpw_pkg::S_DIV) begin
            r_status  <= n_status;
            r_counted <= n_counted;
            r_pix     <= n_pix;
            r_rgb     <= n_rgb;
        end
    end

    assign mem_we = (r_state == abpw_pkg::S_CLEAR)
                 || ((r_state == abpw_pkg::S_DIV) && do_write);
    assign mem_wa = (r_state == abpw_pkg::S_CLEAR) ? r_clr_addr : r_idx;
    assign mem_wd = (r_state == abpw_pkg::S_CLEAR) ? '0 : blend_rgb;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

### hdl/abpw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abpw_checker
// Port-level checks of the alpha blend pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
module abpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("input accepted right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while one is in flight");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[1:0] == abpw_pkg::ST_OOB) |->
            (m_tuser[2] == 1'b0) && (m_tdata == '0))
        else $error("rejected pixel carries data");

    a_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser[2] == ((m_tuser[1:0] == abpw_pkg::ST_WRITTEN)
                                   || (m_tuser[1:0] == abpw_pkg::ST_SKIPPED))))
        else $error("counted flag disagrees with status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind alpha_blend_pixel_writer_core abpw_checker u_abpw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
